[hw/rtl/fpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants of the framed packet receiver
// Action codes, error codes, header layout, checksum seed and the structs
// passed between the parser and the top level.
// ----------------------------------------------------------------------------
package fpr_pkg;

  // Frame geometry
  localparam int HEADER_BYTES  = 10;
  localparam int PAYLOAD_BYTES = 256;
  localparam int BUFFER_BYTES  = 512;
  localparam int CNT_W         = 10;
  localparam int LEN_W         = 16;
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam int SHIFT_W       = 5;
  localparam int SHIFT_WRAP    = 24;
  localparam int LEN_OUT_W     = 9;

  // Header byte positions (1-based beat count)
  localparam logic [CNT_W-1:0] POS_MAGIC_HI = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_MAGIC_LO = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_CMD_HI   = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_CMD_LO   = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_LEN_HI   = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_LEN_LO   = CNT_W'(6);

  localparam logic [7:0]  MAGIC_HI      = 8'h43;
  localparam logic [7:0]  MAGIC_LO      = 8'h77;
  localparam logic [31:0] SUM_START     = 32'h4377_00FF;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [31:0] IDLE_MAX      = 32'hFFFF_FFFF;

  // Configuration register index (taken from paddr[2])
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TIMEOUT  = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_MAGIC    = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_CHECKSUM = 3'd5
  } err_t;

  typedef struct packed {
    logic                 frame_ready;
    err_t                 error_code;
    logic [15:0]          command;
    logic [LEN_OUT_W-1:0] length;
  } status_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

endpackage

[hw/rtl/fpr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/fpr_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_parser: frame state and per-beat update
// Holds the header fields, running checksum, error and ready flags and the
// idle tick counter; updates them once per accepted beat.
// ----------------------------------------------------------------------------
module fpr_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  fpr_pkg::action_t        action,
  input  logic [7:0]              data_byte,
  input  logic [7:0]              read_index,
  input  logic [31:0]             timeout_ticks,
  output fpr_pkg::status_t        status,
  output fpr_pkg::ram_wr_t        ram_wr,
  output logic                    rd_hit
);

  logic [fpr_pkg::CNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [15:0]                 command_r, command_nxt;
  logic [fpr_pkg::LEN_W-1:0]   length_r, length_nxt;
  logic [31:0]                 expected_r, expected_nxt;
  logic [31:0]                 running_r, running_nxt;
  logic [fpr_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  fpr_pkg::err_t               err_r, err_nxt;
  logic                        ready_r, ready_nxt;
  logic [31:0]                 idle_r, idle_nxt;
  logic                        seen_r, seen_nxt;
  logic [7:0]                  first_r, first_nxt;

  logic [fpr_pkg::CNT_W-1:0]   cnt_inc;
  logic [fpr_pkg::CNT_W-1:0]   pay_idx;
  logic [fpr_pkg::LEN_W-1:0]   len_lo;
  logic [31:0]                 sum_new;
  logic [fpr_pkg::LEN_W:0]     frame_end;

  assign cnt_inc   = byte_count_r + fpr_pkg::CNT_W'(1);
  assign pay_idx   = cnt_inc - fpr_pkg::CNT_W'(fpr_pkg::HEADER_BYTES + 1);
  assign len_lo    = {length_r[15:8], data_byte};
  assign sum_new   = running_r ^ ({24'd0, data_byte} << shift_r);
  assign frame_end = {1'b0, length_r} + (fpr_pkg::LEN_W + 1)'(fpr_pkg::HEADER_BYTES);

  // Next frame state for the beat at the input
  always_comb begin
    byte_count_nxt = byte_count_r;
    command_nxt    = command_r;
    length_nxt     = length_r;
    expected_nxt   = expected_r;
    running_nxt    = running_r;
    shift_nxt      = shift_r;
    err_nxt        = err_r;
    ready_nxt      = ready_r;
    idle_nxt       = idle_r;
    seen_nxt       = seen_r;
    first_nxt      = first_r;
    ram_wr.en      = 1'b0;
    ram_wr.addr    = pay_idx[fpr_pkg::IDX_W-1:0];
    ram_wr.data    = data_byte;
    rd_hit         = 1'b0;
    case (action)
      fpr_pkg::ACT_BYTE: begin
        if (err_r == fpr_pkg::ERR_NONE && !ready_r) begin
          if (seen_r && byte_count_r != '0 && idle_r > timeout_ticks) begin
            // Gap too long inside a frame: drop the byte
            err_nxt  = fpr_pkg::ERR_TIMEOUT;
            idle_nxt = '0;
          end else begin
            seen_nxt       = 1'b1;
            idle_nxt       = '0;
            byte_count_nxt = cnt_inc;
            if (cnt_inc >= fpr_pkg::CNT_W'(fpr_pkg::BUFFER_BYTES)) begin
              err_nxt = fpr_pkg::ERR_OVERFLOW;
            end else if (cnt_inc <= fpr_pkg::CNT_W'(fpr_pkg::HEADER_BYTES)) begin
              // Header capture
              case (cnt_inc)
                fpr_pkg::POS_MAGIC_HI: begin
                  first_nxt = data_byte;
                end
                fpr_pkg::POS_MAGIC_LO: begin
                  if (first_r != fpr_pkg::MAGIC_HI || data_byte != fpr_pkg::MAGIC_LO) begin
                    err_nxt = fpr_pkg::ERR_MAGIC;
                  end
                end
                fpr_pkg::POS_CMD_HI: begin
                  command_nxt = {data_byte, command_r[7:0]};
                end
                fpr_pkg::POS_CMD_LO: begin
                  command_nxt = {command_r[15:8], data_byte};
                end
                fpr_pkg::POS_LEN_HI: begin
                  length_nxt = {data_byte, 8'd0};
                end
                fpr_pkg::POS_LEN_LO: begin
                  length_nxt = len_lo;
                  if (len_lo > fpr_pkg::LEN_W'(fpr_pkg::PAYLOAD_BYTES)) begin
                    err_nxt = fpr_pkg::ERR_LENGTH;
                  end
                end
                default: begin
                  expected_nxt = {expected_r[23:0], data_byte};
                  // Empty frame completes on the last header byte
                  if (cnt_inc == fpr_pkg::CNT_W'(fpr_pkg::HEADER_BYTES) &&
                      length_r == '0) begin
                    if (running_r != {expected_r[23:0], data_byte}) begin
                      err_nxt = fpr_pkg::ERR_CHECKSUM;
                    end else begin
                      ready_nxt      = 1'b1;
                      byte_count_nxt = '0;
                    end
                  end
                end
              endcase
            end else begin
              // Payload: store, fold into checksum, check for frame end
              ram_wr.en   = pay_idx < fpr_pkg::CNT_W'(fpr_pkg::PAYLOAD_BYTES);
              running_nxt = sum_new;
              shift_nxt   = (shift_r == fpr_pkg::SHIFT_W'(fpr_pkg::SHIFT_WRAP - 1)) ?
                            '0 : shift_r + fpr_pkg::SHIFT_W'(1);
              if ({7'd0, cnt_inc} >= frame_end) begin
                if (sum_new != expected_r) begin
                  err_nxt = fpr_pkg::ERR_CHECKSUM;
                end else begin
                  ready_nxt      = 1'b1;
                  byte_count_nxt = '0;
                end
              end
            end
          end
        end
      end
      fpr_pkg::ACT_TICK: begin
        if (idle_r != fpr_pkg::IDLE_MAX) begin
          idle_nxt = idle_r + 32'd1;
        end
      end
      fpr_pkg::ACT_CLEAR: begin
        byte_count_nxt = '0;
        length_nxt     = '0;
        expected_nxt   = '0;
        err_nxt        = fpr_pkg::ERR_NONE;
        ready_nxt      = 1'b0;
        running_nxt    = fpr_pkg::SUM_START;
        shift_nxt      = '0;
      end
      fpr_pkg::ACT_READ: begin
        rd_hit = ready_r && ({8'd0, read_index} < length_r);
      end
      default: begin
        rd_hit = 1'b0;
      end
    endcase
    if (!accept) begin
      ram_wr.en = 1'b0;
    end
  end

  // Hold frame state, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      command_r    <= '0;
      length_r     <= '0;
      expected_r   <= '0;
      running_r    <= fpr_pkg::SUM_START;
      shift_r      <= '0;
      err_r        <= fpr_pkg::ERR_NONE;
      ready_r      <= 1'b0;
      idle_r       <= '0;
      seen_r       <= 1'b0;
      first_r      <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      command_r    <= command_nxt;
      length_r     <= length_nxt;
      expected_r   <= expected_nxt;
      running_r    <= running_nxt;
      shift_r      <= shift_nxt;
      err_r        <= err_nxt;
      ready_r      <= ready_nxt;
      idle_r       <= idle_nxt;
      seen_r       <= seen_nxt;
      first_r      <= first_nxt;
    end
  end

  // Status seen after the last accepted beat
  assign status.frame_ready = ready_r;
  assign status.error_code  = err_r;
  assign status.command     = command_r;
  assign status.length      = (length_r > fpr_pkg::LEN_W'({fpr_pkg::LEN_OUT_W{1'b1}})) ?
                              {fpr_pkg::LEN_OUT_W{1'b1}} : length_r[fpr_pkg::LEN_OUT_W-1:0];

endmodule

[hw/rtl/framed_packet_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver: byte-stream frame parser with running checksum
// Parses magic, command, length and checksum, stores the payload and serves
// indexed payload reads.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while out_tready is held high and
// returns exactly one result beat for each. Results pass through the stage
// register and the output register, as the payload RAM's read data is
// registered; the frame state itself is updated in the cycle the beat is
// accepted. These registers let a new beat enter while a result waits, so
// the sustained rate is one beat per cycle. Each result reports the
// frame state after its beat: ready flag, error code, command, payload length
// (saturated at 511) and, for a read action on a ready frame within the
// length, the stored payload byte, else zero. timeout_ticks sits at byte
// address 0 of the configuration port and resets to 1000.
// ----------------------------------------------------------------------------
module framed_packet_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] read_index
  input  logic [1:0]  in_tuser,   // [1:0] action
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] frame_ready, [3:1] error_code,
                                  // [19:4] frame_command, [28:20] frame_length,
                                  // [36:29] read_data, [39:37] zero
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              accept;
  logic              advance;
  fpr_pkg::action_t  in_action;
  fpr_pkg::status_t  status;
  fpr_pkg::ram_wr_t  ram_wr;
  logic              rd_hit;
  logic [7:0]        ram_rd_data;

  logic              s1_valid_r;
  logic              s1_hit_r;
  logic              out_valid_r;
  fpr_pkg::status_t  out_status_r;
  logic [7:0]        out_rd_r;
  logic [31:0]       timeout_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == fpr_pkg::REG_TIMEOUT) ? timeout_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= fpr_pkg::TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == fpr_pkg::REG_TIMEOUT) begin
      timeout_r <= cfg_pwdata;
    end
  end

  // Handshake: accept while the stage register is free or moving on
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;
  assign in_action = fpr_pkg::action_t'(in_tuser);

  fpr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .action        (in_action),
    .data_byte     (in_tdata[7:0]),
    .read_index    (in_tdata[15:8]),
    .timeout_ticks (timeout_r),
    .status        (status),
    .ram_wr        (ram_wr),
    .rd_hit        (rd_hit)
  );

  fpr_ram #(
    .WIDTH (8),
    .DEPTH (fpr_pkg::PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (accept),
    .rd_addr (in_tdata[15:8]),
    .rd_data (ram_rd_data)
  );

  // Stage register: beat accepted, RAM read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_hit_r   <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      s1_hit_r   <= rd_hit;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_status_r <= status;
      out_rd_r     <= s1_hit_r ? ram_rd_data : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_rd_r, out_status_r.length, out_status_r.command,
                       out_status_r.error_code, out_status_r.frame_ready};

  // A held frame never carries an error
  a_ready_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    status.frame_ready |-> status.error_code == fpr_pkg::ERR_NONE)
    else $error("frame ready with error set");

  // A clear beat leaves no frame and no error
  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == fpr_pkg::ACT_CLEAR |=>
      !status.frame_ready && status.error_code == fpr_pkg::ERR_NONE)
    else $error("clear did not reset frame state");

  // A result only appears out of a filled stage register
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r))
    else $error("result without a staged beat");

endmodule
